/* hw/rtl/bbf_pkg.sv */
// Shared types and codes for the block byte FIFO with level thresholds.
// Used by bbf_store and block_byte_fifo_with_thresholds; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbf_pkg;

	// Field widths fixed by the item format
	localparam int CMD_W   = 2;
	localparam int LEN_W   = 7;
	localparam int BYTE_W  = 8;
	localparam int STAT_W  = 3;
	localparam int CNT_W   = 9;
	localparam int CFGI_W  = 2;

	// Commands
	localparam logic [CMD_W-1:0] CMD_WRITE_BEGIN = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_BYTE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ_BLOCK  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd2;
	localparam logic [STAT_W-1:0] STAT_DISCARD   = 3'd3;
	localparam logic [STAT_W-1:0] STAT_STRAY     = 3'd4;

	// Configuration register indexes
	localparam logic [CFGI_W-1:0] CFG_READ_ALERT_ENABLE  = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_READ_ALERT_LEVEL   = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_WRITE_ALERT_ENABLE = 2'd2;
	localparam logic [CFGI_W-1:0] CFG_WRITE_ALERT_LEVEL  = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [LEN_W-1:0]  block_length;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] out_byte;
		logic              is_last;
		logic [CNT_W-1:0]  readable_count;
		logic [CNT_W-1:0]  writable_count;
		logic              data_alert;
		logic              space_alert;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/bbf_store.sv */
// Byte store of the block FIFO: one write port, one read port, registered read data.
// Depends on bbf_pkg for the byte width.
`timescale 1ns / 1ps
`default_nettype none

module bbf_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [AW-1:0]             wr_addr,
	input  wire logic [bbf_pkg::BYTE_W-1:0] wr_data,
	input  wire logic                      rd_en,
	input  wire logic [AW-1:0]             rd_addr,
	output logic      [bbf_pkg::BYTE_W-1:0] rd_data
);
	import bbf_pkg::*;

	logic [BYTE_W-1:0] mem_q [DEPTH];

	// Store one byte per write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Register read data; hold it while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/block_byte_fifo_with_thresholds.sv */
// Top level of the block byte FIFO with level thresholds.
// Depends on bbf_pkg (types, codes) and bbf_store (byte memory).
`timescale 1ns / 1ps
`default_nettype none

// Circular byte FIFO with all-or-nothing block writes and block reads. A write-begin
// item reserves a block; the write-byte items that follow are stored (or discarded if
// the block was refused), one item per cycle while the output is not stalled, with one
// result beat each. A read item of length n produces n result beats, the last one marked,
// streamed one per cycle out of the single-port-read byte memory while the output is not
// stalled; the input stays stalled while the burst drains through the registered memory
// read. The input also stalls while a finished result waits in the output register and
// the output is stalled. Every beat reports the readable and writable counts after the
// item; data_alert and space_alert fire when a block completes and the enabled threshold
// is met. The memory needs no clearing pass.
// Configuration writes are always ready and should be issued only while idle.
module block_byte_fifo_with_thresholds #(
	parameter int CAPACITY  = 256,
	parameter int MAX_BLOCK = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire bbf_pkg::item_t              item,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output bbf_pkg::result_t                 result,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [bbf_pkg::CFGI_W-1:0]  cfg_index,
	input  wire logic [bbf_pkg::CNT_W-1:0]   cfg_data
);
	import bbf_pkg::*;

	localparam int PW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CW > CNT_W) ? CW : CNT_W;

	typedef enum logic {ST_IDLE, ST_READ} state_t;

	// Registers
	state_t            state_q;
	logic [PW-1:0]     rd_ptr_q, wr_ptr_q, raddr_q;
	logic [CW-1:0]     fill_q;
	logic [LEN_W-1:0]  pend_q, iss_left_q, emit_left_q;
	logic              disc_q, sal_q;
	logic              data_v_s1;
	logic              result_valid_q;
	result_t           result_q;
	logic              ra_en_q, wa_en_q;
	logic [CNT_W-1:0]  ra_lvl_q, wa_lvl_q;

	// Next-state logic
	logic              load_ok, accept, rd_en, beat_load;
	logic              imm_load, burst_go, mem_we;
	result_t           imm;
	logic [CW-1:0]     fill_nxt;
	logic [PW-1:0]     rd_ptr_nxt, wr_ptr_nxt;
	logic [LEN_W-1:0]  pend_nxt;
	logic              disc_nxt, sal_nxt;
	logic [CMP_W-1:0]  len_x, fill_x, wrbl_x;
	logic [BYTE_W-1:0] mem_rdata;

	function automatic logic [CMP_W-1:0] free_of(input logic [CW-1:0] f);
		logic [CMP_W-1:0] fx;
		fx = CMP_W'(f);
		return CMP_W'(CAPACITY) - fx;
	endfunction

	function automatic logic data_alert_of(input logic [CW-1:0] f, input logic en,
		input logic [CNT_W-1:0] lvl);
		return en && (CMP_W'(f) >= CMP_W'(lvl));
	endfunction

	function automatic logic space_alert_of(input logic [CW-1:0] f, input logic en,
		input logic [CNT_W-1:0] lvl);
		return en && (free_of(f) >= CMP_W'(lvl));
	endfunction

	assign cfg_ready    = 1'b1;
	assign load_ok      = !result_valid_q || !result_stall;
	assign item_stall   = (state_q != ST_IDLE) || !load_ok;
	assign accept       = item_valid && !item_stall;
	assign rd_en        = (state_q == ST_READ) && (iss_left_q != '0) && (!data_v_s1 || load_ok);
	assign beat_load    = data_v_s1 && load_ok;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign len_x  = CMP_W'(item.block_length);
	assign fill_x = CMP_W'(fill_q);
	assign wrbl_x = free_of(fill_q);

	// Decode the accepted item: immediate result and state updates
	always_comb begin
		logic [CMP_W-1:0] fill_nxt_x;
		logic [CMP_W-1:0] free_nxt_x;
		imm        = '0;
		imm.is_last = 1'b1;
		imm_load   = 1'b0;
		burst_go   = 1'b0;
		mem_we     = 1'b0;
		fill_nxt   = fill_q;
		rd_ptr_nxt = rd_ptr_q;
		wr_ptr_nxt = wr_ptr_q;
		pend_nxt   = pend_q;
		disc_nxt   = disc_q;
		sal_nxt    = sal_q;
		if (accept) begin
			unique case (item.command)
				CMD_WRITE_BEGIN: begin
					imm_load = 1'b1;
					if (pend_q != '0) begin
						imm.status = STAT_OVERFLOW;
					end else if (len_x > CMP_W'(MAX_BLOCK) || len_x > wrbl_x) begin
						pend_nxt   = item.block_length;
						disc_nxt   = (item.block_length != '0);
						imm.status = STAT_OVERFLOW;
					end else begin
						pend_nxt       = item.block_length;
						disc_nxt       = 1'b0;
						imm.status     = STAT_OK;
						imm.data_alert = (item.block_length == '0) &&
							data_alert_of(fill_q, ra_en_q, ra_lvl_q);
					end
				end
				CMD_WRITE_BYTE: begin
					imm_load = 1'b1;
					if (pend_q == '0) begin
						imm.status = STAT_STRAY;
					end else begin
						pend_nxt = pend_q - LEN_W'(1);
						if (disc_q) begin
							disc_nxt   = (pend_nxt != '0);
							imm.status = STAT_DISCARD;
						end else begin
							if (fill_x < CMP_W'(CAPACITY)) begin
								mem_we     = 1'b1;
								wr_ptr_nxt = wr_ptr_q + PW'(1);
								fill_nxt   = fill_q + CW'(1);
							end
							imm.status     = STAT_OK;
							imm.data_alert = (pend_nxt == '0) &&
								data_alert_of(fill_nxt, ra_en_q, ra_lvl_q);
						end
					end
				end
				CMD_READ_BLOCK: begin
					if (len_x > CMP_W'(MAX_BLOCK) || len_x > fill_x) begin
						imm_load   = 1'b1;
						imm.status = STAT_UNDERFLOW;
					end else begin
						fill_nxt   = fill_q - len_x[CW-1:0];
						rd_ptr_nxt = rd_ptr_q + len_x[PW-1:0];
						sal_nxt    = space_alert_of(fill_nxt, wa_en_q, wa_lvl_q);
						if (item.block_length == '0) begin
							imm_load        = 1'b1;
							imm.status      = STAT_OK;
							imm.space_alert = sal_nxt;
						end else begin
							burst_go = 1'b1;
						end
					end
				end
				CMD_UNUSED: begin
					imm_load = 1'b0;
				end
			endcase
		end
		fill_nxt_x         = CMP_W'(fill_nxt);
		free_nxt_x         = free_of(fill_nxt);
		imm.readable_count = fill_nxt_x[CNT_W-1:0];
		imm.writable_count = free_nxt_x[CNT_W-1:0];
	end

	// Hold control state, burst counters and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		logic [CMP_W-1:0] fq_x;
		logic [CMP_W-1:0] fr_x;
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rd_ptr_q       <= '0;
			wr_ptr_q       <= '0;
			raddr_q        <= '0;
			fill_q         <= '0;
			pend_q         <= '0;
			disc_q         <= 1'b0;
			sal_q          <= 1'b0;
			iss_left_q     <= '0;
			emit_left_q    <= '0;
			data_v_s1      <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			fq_x = CMP_W'(fill_q);
			fr_x = free_of(fill_q);
			rd_ptr_q <= rd_ptr_nxt;
			wr_ptr_q <= wr_ptr_nxt;
			fill_q   <= fill_nxt;
			pend_q   <= pend_nxt;
			disc_q   <= disc_nxt;
			sal_q    <= sal_nxt;

			// Start a read burst from the old read pointer
			if (burst_go) begin
				state_q     <= ST_READ;
				raddr_q     <= rd_ptr_q;
				iss_left_q  <= item.block_length;
				emit_left_q <= item.block_length;
			end

			// Advance the memory read side
			if (rd_en) begin
				raddr_q    <= raddr_q + PW'(1);
				iss_left_q <= iss_left_q - LEN_W'(1);
			end
			data_v_s1 <= rd_en || (data_v_s1 && !load_ok);

			// Load the output register from a burst beat or an immediate result
			if (beat_load) begin
				result_valid_q          <= 1'b1;
				result_q.status         <= STAT_OK;
				result_q.out_byte       <= mem_rdata;
				result_q.is_last        <= (emit_left_q == LEN_W'(1));
				result_q.readable_count <= fq_x[CNT_W-1:0];
				result_q.writable_count <= fr_x[CNT_W-1:0];
				result_q.data_alert     <= 1'b0;
				result_q.space_alert    <= (emit_left_q == LEN_W'(1)) && sal_q;
				emit_left_q             <= emit_left_q - LEN_W'(1);
				if (emit_left_q == LEN_W'(1)) begin
					state_q <= ST_IDLE;
				end
			end else if (imm_load) begin
				result_valid_q <= 1'b1;
				result_q       <= imm;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ra_en_q  <= 1'b0;
			ra_lvl_q <= '0;
			wa_en_q  <= 1'b0;
			wa_lvl_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_READ_ALERT_ENABLE:  ra_en_q  <= cfg_data[0];
				CFG_READ_ALERT_LEVEL:   ra_lvl_q <= cfg_data;
				CFG_WRITE_ALERT_ENABLE: wa_en_q  <= cfg_data[0];
				CFG_WRITE_ALERT_LEVEL:  wa_lvl_q <= cfg_data;
			endcase
		end
	end

	bbf_store #(
		.DEPTH (CAPACITY),
		.AW    (PW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (wr_ptr_q),
		.wr_data (item.data_byte),
		.rd_en   (rd_en),
		.rd_addr (raddr_q),
		.rd_data (mem_rdata)
	);

	// Pointers and fill level stay consistent
	a_ptr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == fill_q[PW-1:0])
		else $error("pointer distance does not match fill level");

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(fill_q) <= CMP_W'(CAPACITY))
		else $error("fill level above capacity");

	// No burst work outstanding while idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (emit_left_q == '0 && iss_left_q == '0 && !data_v_s1))
		else $error("burst activity while idle");

	// A beat that cannot be loaded keeps its memory data
	a_beat_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(data_v_s1 && !load_ok) |=> (data_v_s1 && $stable(mem_rdata)))
		else $error("stalled read beat lost");

endmodule

`default_nettype wire
